// File: sv/pps_pkg.sv
// Package for the perspective projection setup block: constants, types and helper functions.
package pps_pkg;

  // Fixed-point formats
  localparam int FRACTION_BITS = 16;  // fraction bits of the four matrix outputs
  localparam int CORDIC_STEPS  = 24;  // CORDIC iterations, one pipeline stage each
  localparam int ASP_FRAC      = 16;  // fraction bits of the aspect input

  // Divider geometry: quotient bits, divisor width, numerator width
  localparam int QW     = 41;                       // covers f up to its clamp of 2^40
  localparam int DW     = 39;                       // widest divisor: distance << DOF_DSH
  localparam int DOF_SH = FRACTION_BITS - 8;        // numerator shift of the depth offset
  localparam int DOF_DSH = 7;                       // divisor shift of the depth offset
  localparam int NW     = 64 + DOF_SH;              // widest numerator: far*near << DOF_SH
  localparam int MAG_W  = QW + 1;                   // rounded quotient width

  // CORDIC datapath width (Q2.30 with headroom)
  localparam int CW = 34;

  // Constants
  localparam logic [31:0]      PI_Q30    = 32'd3373259426;
  localparam logic [15:0]      FOV_LIMIT = 16'd46080;
  localparam logic [MAG_W-1:0] F_CLAMP   = MAG_W'(1) << (QW - 1);
  localparam logic signed [CW-1:0] CORDIC_ONE = CW'(1) <<< 30;

  // Half fov to radians: fov * PI_Q30 / Z_DIV, split as fov*Z_INT + fov*Z_FRAC/Z_DIV.
  // The rounded remainder term is (2t + Z_DIV) >> Z_PRE, then a divide by 45 done
  // as a multiply by Z_RECIP and a shift by Z_RSH (exact for 20-bit operands).
  localparam logic [31:0] Z_DIV   = 32'd92160;
  localparam logic [15:0] Z_INT   = 16'd36602;
  localparam logic [15:0] Z_FRAC  = 16'd19106;
  localparam int          Z_PRE   = 12;
  localparam logic [20:0] Z_RECIP = 21'd1491309;
  localparam int          Z_RSH   = 26;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_FOV   = 2'd1;
  localparam logic [1:0] ST_ASP_ZERO  = 2'd2;
  localparam logic [1:0] ST_PLANES_EQ = 2'd3;

  // Per-item data that rides along the pipeline next to the arithmetic
  typedef struct packed {
    logic [23:0] asp;
    logic        fov_ok;
    logic        nf_eq;
    logic [1:0]  status;
    logic        dneg;
    logic        negf;
    logic        yzero;
    logic [31:0] zhi;
    logic [30:0] zlo;
    logic [31:0] ys;
    logic [31:0] dsc;
    logic [31:0] dof;
  } pps_side_t;

  // atan(2^-i) in Q2.30
  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] a;
    case (i)
      0:  a = CW'(843314857);
      1:  a = CW'(497837829);
      2:  a = CW'(263043837);
      3:  a = CW'(133525159);
      4:  a = CW'(67021687);
      5:  a = CW'(33543516);
      6:  a = CW'(16775851);
      7:  a = CW'(8388437);
      8:  a = CW'(4194283);
      9:  a = CW'(2097149);
      10: a = CW'(1048576);
      11: a = CW'(524288);
      12: a = CW'(262144);
      13: a = CW'(131072);
      14: a = CW'(65536);
      15: a = CW'(32768);
      16: a = CW'(16384);
      17: a = CW'(8192);
      18: a = CW'(4096);
      19: a = CW'(2048);
      20: a = CW'(1024);
      21: a = CW'(512);
      22: a = CW'(256);
      23: a = CW'(128);
      24: a = CW'(64);
      25: a = CW'(32);
      26: a = CW'(16);
      27: a = CW'(8);
      28: a = CW'(4);
      29: a = CW'(2);
      30: a = CW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

  // Sign and magnitude to a saturated 32-bit two's complement word
  function automatic logic [31:0] pack_q(input logic neg, input logic ovf,
                                         input logic [MAG_W-1:0] mag);
    logic [31:0] res;
    if (!neg) begin
      res = (ovf || mag > MAG_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      res = (ovf || mag >= MAG_W'(33'h0_8000_0000)) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    end
    return res;
  endfunction

endpackage

// File: sv/perspective_projection_setup.sv
// Perspective projection setup: pipeline from fov, aspect and clip planes to matrix entries.
// One parameter set is taken per cycle while in_stall is low, and results come out in order,
// one per item. The path runs through stages A and B, the two depth dividers (far+near and
// 2*far*near over the plane distance), which the half-fov angle rides alongside, then the
// CORDIC and two more bit-per-stage dividers in series (cos/sin quotient, division by
// aspect), and the output register. The angle itself is a short multiply and reciprocal
// step. A held stall freezes the whole pipeline, so in_stall follows out_stall while a
// result is waiting.
module perspective_projection_setup (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        fov_degrees,
  input  logic [23:0]        aspect,
  input  logic [31:0]        near_plane,
  input  logic [31:0]        far_plane,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] x_scale,
  output logic signed [31:0] y_scale,
  output logic signed [31:0] depth_scale,
  output logic signed [31:0] depth_offset,
  output logic [1:0]         status
);
  import pps_pkg::*;

  logic adv;

  // Stage A: input registers
  logic        a_v;
  logic [15:0] a_fov;
  logic [23:0] a_asp;
  logic [31:0] a_near, a_far;

  // Stage B: products, sum, distance, flags
  logic        b_v;
  logic [63:0] b_pnf;
  logic [32:0] b_sum;
  logic [31:0] b_dist;
  pps_side_t   b_side, b_side_next;

  // Divider and CORDIC outputs
  logic             c_v, s_ovf, o_ovf;
  logic [MAG_W-1:0] s_mag, o_mag;
  pps_side_t        c_side, side_c;
  logic [31:0]      z_sum;
  logic [19:0]      z_u;
  logic [40:0]      z_prod;
  logic [CW-1:0]    z_rad;
  logic             e_v;
  logic [CW-1:0]    e_xmag, e_ymag;
  pps_side_t        e_side;
  logic             f_v, f_ovf;
  logic [MAG_W-1:0] f_mag;
  pps_side_t        f_side, side_g;
  logic [QW-1:0]    magf;
  logic             h_v, h_ovf;
  logic [MAG_W-1:0] h_mag;
  pps_side_t        h_side;

  // Whole pipeline moves unless a finished result is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage A
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= in_valid;
    end
    if (adv) begin
      a_fov  <= fov_degrees;
      a_asp  <= aspect;
      a_near <= near_plane;
      a_far  <= far_plane;
    end
  end

  // Flags, status priority and the two angle products
  always_comb begin
    b_side_next        = '0;
    b_side_next.asp    = a_asp;
    b_side_next.fov_ok = (a_fov != '0) && (a_fov < FOV_LIMIT);
    b_side_next.nf_eq  = a_near == a_far;
    b_side_next.dneg   = a_near < a_far;
    b_side_next.zhi    = 32'(a_fov) * 32'(Z_INT);
    b_side_next.zlo    = 31'(a_fov) * 31'(Z_FRAC);
    if (!b_side_next.fov_ok) begin
      b_side_next.status = ST_BAD_FOV;
    end else if (a_asp == '0) begin
      b_side_next.status = ST_ASP_ZERO;
    end else if (b_side_next.nf_eq) begin
      b_side_next.status = ST_PLANES_EQ;
    end else begin
      b_side_next.status = ST_OK;
    end
  end

  // Stage B
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= a_v;
    end
    if (adv) begin
      b_pnf  <= 64'(a_near) * 64'(a_far);
      b_sum  <= 33'(a_near) + 33'(a_far);
      b_dist <= b_side_next.dneg ? (a_far - a_near) : (a_near - a_far);
      b_side <= b_side_next;
    end
  end

  // Depth scale: (far+near) / distance; carries the item's side data
  pps_div u_div_s (
    .clk, .rst, .adv,
    .v_in     (b_v),
    .n_in     (NW'(b_sum) << FRACTION_BITS),
    .d_in     (DW'(b_dist)),
    .side_in  (b_side),
    .v_out    (c_v),
    .mag_out  (s_mag),
    .ovf_out  (s_ovf),
    .side_out (c_side)
  );

  // Depth offset: 2*far*near / distance, scaled so both shifts stay non-negative
  pps_div u_div_o (
    .clk, .rst, .adv,
    .v_in     (b_v),
    .n_in     (NW'(b_pnf) << DOF_SH),
    .d_in     (DW'(b_dist) << DOF_DSH),
    .side_in  (b_side),
    .v_out    (),
    .mag_out  (o_mag),
    .ovf_out  (o_ovf),
    .side_out ()
  );

  // Pack depth terms into the side data; finish half fov in radians, Q2.30
  always_comb begin
    side_c     = c_side;
    side_c.dsc = c_side.nf_eq ? '0 : pack_q(c_side.dneg, s_ovf, s_mag);
    side_c.dof = c_side.nf_eq ? '0 : pack_q(c_side.dneg, o_ovf, o_mag);
    z_sum      = {c_side.zlo, 1'b0} + Z_DIV;
    z_u        = 20'(z_sum >> Z_PRE);
    z_prod     = 41'(z_u) * 41'(Z_RECIP);
    z_rad      = CW'(c_side.zhi) + CW'(z_prod >> Z_RSH);
  end

  pps_cordic u_cordic (
    .clk, .rst, .adv,
    .v_in     (c_v),
    .z_in     (signed'(z_rad)),
    .side_in  (side_c),
    .v_out    (e_v),
    .xmag_out (e_xmag),
    .ymag_out (e_ymag),
    .side_out (e_side)
  );

  // f = cos / sin
  pps_div u_div_f (
    .clk, .rst, .adv,
    .v_in     (e_v),
    .n_in     (NW'(e_xmag) << FRACTION_BITS),
    .d_in     (DW'(e_ymag)),
    .side_in  (e_side),
    .v_out    (f_v),
    .mag_out  (f_mag),
    .ovf_out  (f_ovf),
    .side_out (f_side)
  );

  // Clamp f, form y scale
  always_comb begin
    if (f_side.yzero || f_ovf || f_mag > F_CLAMP) begin
      magf = F_CLAMP[QW-1:0];
    end else begin
      magf = f_mag[QW-1:0];
    end
    side_g    = f_side;
    side_g.ys = f_side.fov_ok ? pack_q(f_side.negf, 1'b0, MAG_W'(magf)) : '0;
  end

  // x scale = f / aspect
  pps_div u_div_x (
    .clk, .rst, .adv,
    .v_in     (f_v),
    .n_in     (NW'(magf) << ASP_FRAC),
    .d_in     (DW'(f_side.asp)),
    .side_in  (side_g),
    .v_out    (h_v),
    .mag_out  (h_mag),
    .ovf_out  (h_ovf),
    .side_out (h_side)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= h_v;
    end
    if (adv) begin
      x_scale      <= (h_side.fov_ok && h_side.asp != '0) ?
                      signed'(pack_q(h_side.negf, h_ovf, h_mag)) : '0;
      y_scale      <= signed'(h_side.ys);
      depth_scale  <= signed'(h_side.dsc);
      depth_offset <= signed'(h_side.dof);
      status       <= h_side.status;
    end
  end

endmodule

// File: sv/pps_div.sv
// Pipelined restoring divider, one quotient bit per stage, round half up, overflow flag.
module pps_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      v_in,
  input  logic [pps_pkg::NW-1:0]    n_in,
  input  logic [pps_pkg::DW-1:0]    d_in,
  input  pps_pkg::pps_side_t        side_in,
  output logic                      v_out,
  output logic [pps_pkg::MAG_W-1:0] mag_out,
  output logic                      ovf_out,
  output pps_pkg::pps_side_t        side_out
);
  import pps_pkg::*;

  logic            v    [0:QW];
  logic [DW-1:0]   rem  [0:QW];
  logic [QW-1:0]   nlo  [0:QW-1];
  logic [QW-1:0]   quo  [0:QW];
  logic [DW-1:0]   den  [0:QW];
  logic            ovf  [0:QW];
  pps_side_t       side [0:QW];
  logic            up;

  // Entry: split numerator, flag quotients that do not fit in QW bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= v_in;
    end
    if (adv) begin
      rem[0]  <= DW'(n_in >> QW);
      nlo[0]  <= n_in[QW-1:0];
      quo[0]  <= '0;
      den[0]  <= d_in;
      ovf[0]  <= (n_in >> QW) >= NW'(d_in);
      side[0] <= side_in;
    end
  end

  // One compare-subtract per stage
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] t;
    logic        ge;

    always_comb begin
      t  = {rem[k], nlo[k][QW-1]};
      ge = t >= {1'b0, den[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (adv) begin
        v[k+1] <= v[k];
      end
      if (adv) begin
        rem[k+1]  <= ge ? DW'(t - {1'b0, den[k]}) : t[DW-1:0];
        quo[k+1]  <= {quo[k][QW-2:0], ge};
        den[k+1]  <= den[k];
        ovf[k+1]  <= ovf[k];
        side[k+1] <= side[k];
      end
    end

    if (k < QW - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (adv) begin
          nlo[k+1] <= nlo[k] << 1;
        end
      end
    end
  end

  // Round: add one when twice the remainder reaches the divisor
  assign up = {rem[QW], 1'b0} >= {1'b0, den[QW]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (adv) begin
      v_out <= v[QW];
    end
    if (adv) begin
      mag_out  <= MAG_W'(quo[QW]) + MAG_W'(up);
      ovf_out  <= ovf[QW];
      side_out <= side[QW];
    end
  end

endmodule

// File: sv/pps_cordic.sv
// Rotation-mode CORDIC pipeline giving gain-scaled cos and sin magnitudes and the sign of their quotient.
module pps_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          v_in,
  input  logic signed [pps_pkg::CW-1:0] z_in,
  input  pps_pkg::pps_side_t            side_in,
  output logic                          v_out,
  output logic [pps_pkg::CW-1:0]        xmag_out,
  output logic [pps_pkg::CW-1:0]        ymag_out,
  output pps_pkg::pps_side_t            side_out
);
  import pps_pkg::*;

  logic                 v    [0:CORDIC_STEPS];
  logic signed [CW-1:0] xr   [0:CORDIC_STEPS];
  logic signed [CW-1:0] yr   [0:CORDIC_STEPS];
  logic signed [CW-1:0] zr   [0:CORDIC_STEPS];
  pps_side_t            side [0:CORDIC_STEPS];

  logic                 xneg, yneg, yz;
  pps_side_t            side_next;

  // Entry: start vector on the x axis
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= v_in;
    end
    if (adv) begin
      xr[0]   <= CORDIC_ONE;
      yr[0]   <= '0;
      zr[0]   <= z_in;
      side[0] <= side_in;
    end
  end

  // One micro-rotation per stage, fixed shift
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [CW-1:0] dx, dy;

    always_comb begin
      dx = yr[i] >>> i;
      dy = xr[i] >>> i;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (adv) begin
        v[i+1] <= v[i];
      end
      if (adv) begin
        if (!zr[i][CW-1]) begin
          xr[i+1] <= xr[i] - dx;
          yr[i+1] <= yr[i] + dy;
          zr[i+1] <= zr[i] - atan_q30(i);
        end else begin
          xr[i+1] <= xr[i] + dx;
          yr[i+1] <= yr[i] - dy;
          zr[i+1] <= zr[i] + atan_q30(i);
        end
        side[i+1] <= side[i];
      end
    end
  end

  // Output: magnitudes and quotient sign
  always_comb begin
    xneg = xr[CORDIC_STEPS][CW-1];
    yneg = yr[CORDIC_STEPS][CW-1];
    yz   = yr[CORDIC_STEPS] == '0;
    side_next       = side[CORDIC_STEPS];
    side_next.yzero = yz;
    side_next.negf  = yz ? xneg : (xneg != yneg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (adv) begin
      v_out <= v[CORDIC_STEPS];
    end
    if (adv) begin
      xmag_out <= xneg ? CW'(-xr[CORDIC_STEPS]) : CW'(xr[CORDIC_STEPS]);
      ymag_out <= yneg ? CW'(-yr[CORDIC_STEPS]) : CW'(yr[CORDIC_STEPS]);
      side_out <= side_next;
    end
  end

endmodule
